// ===== rtl/core/sbkv_pkg.sv =====
// ----------------------------------------------------------------------------
// sbkv_pkg: shared types and constants for the sorted key/value table
// Sizes, op codes, beat structs and cell control types used by the cell
// chain and the top level.
// ----------------------------------------------------------------------------
package sbkv_pkg;

  // Table geometry
  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  // Fixed field widths
  localparam int OP_BITS   = 3;
  localparam int CAP_BITS  = 5;
  localparam int KEEP_BITS = 5;
  localparam int OCC_BITS  = 5;
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  // Register port
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;
  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [OP_BITS-1:0] {
    OP_INSERT = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_TRIM   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SHIFT
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Input beat
  typedef struct packed {
    logic [OP_BITS-1:0]          op;
    logic signed [KEY_BITS-1:0]  key;
    logic [VALUE_BITS-1:0]       value;
    logic [KEEP_BITS-1:0]        keep_count;
  } item_t;

  // Result beat
  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic [OCC_BITS-1:0]   occupancy;
  } result_t;

  // Control broadcast to every cell
  typedef struct packed {
    cell_op_t                    op;
    logic                        evict;
    logic signed [KEY_BITS-1:0]  key;
    logic [VALUE_BITS-1:0]       value;
  } cell_ctl_t;

  // Status returned by the chain
  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
  } chain_stat_t;

endpackage

// ===== rtl/core/sbkv_cell.sv =====
// ----------------------------------------------------------------------------
// sbkv_cell: one slot of the sorted table
// Holds one key/value pair, compares it with the broadcast key and loads
// from itself, a neighbor or the new entry depending on the operation.
// ----------------------------------------------------------------------------
module sbkv_cell (
  input  logic                                  clk,
  input  sbkv_pkg::cell_ctl_t                   ctl,
  input  logic                                  head,
  input  logic                                  valid,
  input  logic signed [sbkv_pkg::KEY_BITS-1:0]  left_key,
  input  logic [sbkv_pkg::VALUE_BITS-1:0]       left_value,
  input  logic                                  left_le,
  input  logic signed [sbkv_pkg::KEY_BITS-1:0]  right_key,
  input  logic [sbkv_pkg::VALUE_BITS-1:0]       right_value,
  input  logic                                  right_le,
  output logic signed [sbkv_pkg::KEY_BITS-1:0]  key,
  output logic [sbkv_pkg::VALUE_BITS-1:0]       value,
  output logic                                  le,
  output logic                                  eq
);

  logic signed [sbkv_pkg::KEY_BITS-1:0] key_next;
  logic [sbkv_pkg::VALUE_BITS-1:0]      value_next;
  logic                                 lt;

  // Local compare against the broadcast key
  assign le = valid && (key <= ctl.key);
  assign lt = valid && (key < ctl.key);
  assign eq = valid && (key == ctl.key);

  // Slot load select
  always_comb begin
    key_next   = key;
    value_next = value;
    unique case (ctl.op)
      sbkv_pkg::CELL_INSERT: begin
        if (ctl.evict) begin
          // front entry drops out: the entries up to the new key move one slot toward head
          if (right_le) begin
            key_next   = right_key;
            value_next = right_value;
          end else if (head || le) begin
            key_next   = ctl.key;
            value_next = ctl.value;
          end
        end else if (!le) begin
          if (head || left_le) begin
            key_next   = ctl.key;
            value_next = ctl.value;
          end else begin
            key_next   = left_key;
            value_next = left_value;
          end
        end
      end
      sbkv_pkg::CELL_REMOVE: begin
        // slots at and past the first match close the gap
        if (!lt) begin
          key_next   = right_key;
          value_next = right_value;
        end
      end
      sbkv_pkg::CELL_SHIFT: begin
        key_next   = right_key;
        value_next = right_value;
      end
      sbkv_pkg::CELL_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    value <= value_next;
  end

endmodule

// ===== rtl/core/sbkv_chain.sv =====
// ----------------------------------------------------------------------------
// sbkv_chain: row of table cells
// Links the cells to their neighbors, derives slot valid from the count and
// reduces the per-cell match flags into found and the lookup value.
// ----------------------------------------------------------------------------
module sbkv_chain (
  input  logic                             clk,
  input  sbkv_pkg::cell_ctl_t              ctl,
  input  logic [sbkv_pkg::CNT_BITS-1:0]    count,
  output sbkv_pkg::chain_stat_t            stat
);

  logic signed [sbkv_pkg::KEY_BITS-1:0] cell_key   [sbkv_pkg::DEPTH];
  logic [sbkv_pkg::VALUE_BITS-1:0]      cell_value [sbkv_pkg::DEPTH];
  logic [sbkv_pkg::DEPTH-1:0]           cell_le;
  logic [sbkv_pkg::DEPTH-1:0]           cell_eq;
  logic [sbkv_pkg::DEPTH-1:0]           first_eq;
  logic                                 found;
  sbkv_pkg::cell_ctl_t                  cell_ctl;

  assign found = |cell_eq;

  // A remove with no match leaves the row alone
  always_comb begin
    cell_ctl = ctl;
    if (ctl.op == sbkv_pkg::CELL_REMOVE && !found) begin
      cell_ctl.op = sbkv_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < sbkv_pkg::DEPTH; i++) begin : g_cell
    logic signed [sbkv_pkg::KEY_BITS-1:0] lkey;
    logic [sbkv_pkg::VALUE_BITS-1:0]      lvalue;
    logic                                 lle;
    logic signed [sbkv_pkg::KEY_BITS-1:0] rkey;
    logic [sbkv_pkg::VALUE_BITS-1:0]      rvalue;
    logic                                 rle;

    if (i == 0) begin : g_head
      assign lkey   = '0;
      assign lvalue = '0;
      assign lle    = 1'b0;
      assign first_eq[i] = cell_eq[i];
    end else begin : g_body
      assign lkey   = cell_key[i-1];
      assign lvalue = cell_value[i-1];
      assign lle    = cell_le[i-1];
      // equal keys sit together, so the first match has no match before it
      assign first_eq[i] = cell_eq[i] && !cell_eq[i-1];
    end

    if (i == sbkv_pkg::DEPTH - 1) begin : g_tail
      assign rkey   = '0;
      assign rvalue = '0;
      assign rle    = 1'b0;
    end else begin : g_mid
      assign rkey   = cell_key[i+1];
      assign rvalue = cell_value[i+1];
      assign rle    = cell_le[i+1];
    end

    sbkv_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .head        (i == 0),
      .valid       (count > sbkv_pkg::CNT_BITS'(i)),
      .left_key    (lkey),
      .left_value  (lvalue),
      .left_le     (lle),
      .right_key   (rkey),
      .right_value (rvalue),
      .right_le    (rle),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .le          (cell_le[i]),
      .eq          (cell_eq[i])
    );
  end

  // One-hot select of the first matching value
  always_comb begin
    stat.found      = found;
    stat.read_value = '0;
    for (int j = 0; j < sbkv_pkg::DEPTH; j++) begin
      stat.read_value = stat.read_value |
                        ({sbkv_pkg::VALUE_BITS{first_eq[j]}} & cell_value[j]);
    end
  end

endmodule

// ===== rtl/core/sorted_bounded_key_value_table.sv =====
// ----------------------------------------------------------------------------
// sorted_bounded_key_value_table: bounded table kept in signed key order
// Insert with smallest-key eviction, lookup, remove, clear and trim over a
// row of shifting cells, with a capacity register on an APB-style port.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | beat
//  ---------+-----------+----------------------------+---------------------
//  cmd      | in        | cmd_valid / cmd_stall      | item_t (op,key,...)
//  res      | out       | res_valid / res_stall      | result_t
//  apb      | in/out    | psel,penable,pwrite,pready | capacity register
//
//  Insert, lookup, remove, clear and unused ops: the beat is taken in idle,
//  then the cell row compares and shifts in place in the execute state.
//  Trim evicts n entries in the execute state: the row shifts one slot a cycle.
//  Reset (rst, synchronous) empties the table and sets capacity to 16.
//  A new beat is taken while a result waits in the output register; a held
//  result stalls the next operation in its execute cycle.
// ----------------------------------------------------------------------------
module sorted_bounded_key_value_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  sbkv_pkg::item_t                    cmd,
  output logic                               res_valid,
  input  logic                               res_stall,
  output sbkv_pkg::result_t                  res,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sbkv_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [sbkv_pkg::DATA_BITS-1:0]     pwdata,
  output logic [sbkv_pkg::DATA_BITS-1:0]     prdata,
  output logic                               pready
);

  sbkv_pkg::state_t              state, state_next;
  sbkv_pkg::item_t               item;
  logic [sbkv_pkg::CAP_BITS-1:0] capacity;
  logic [sbkv_pkg::CNT_BITS-1:0] count, count_next;
  sbkv_pkg::cell_ctl_t           ctl;
  sbkv_pkg::chain_stat_t         stat;
  sbkv_pkg::result_t             result_next;
  logic                          finish;
  logic                          out_free;
  logic                          evict;
  logic [sbkv_pkg::CMP_BITS-1:0] count_w;
  logic [sbkv_pkg::CMP_BITS-1:0] cap_w;
  logic [sbkv_pkg::CMP_BITS-1:0] keep_w;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sbkv_pkg::REG_CAPACITY) ?
                  sbkv_pkg::DATA_BITS'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sbkv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == sbkv_pkg::REG_CAPACITY) begin
      capacity <= pwdata[sbkv_pkg::CAP_BITS-1:0];
    end
  end

  // Eviction: capacity zero acts as one, above the depth as the depth
  assign count_w = sbkv_pkg::CMP_BITS'(count);
  assign cap_w   = (capacity == '0) ? sbkv_pkg::CMP_BITS'(1) : sbkv_pkg::CMP_BITS'(capacity);
  assign keep_w  = sbkv_pkg::CMP_BITS'(item.keep_count);
  assign evict   = (count != '0) &&
                   ((count >= sbkv_pkg::CNT_BITS'(sbkv_pkg::DEPTH)) || (count_w >= cap_w));

  assign cmd_stall = (state != sbkv_pkg::ST_IDLE);
  assign out_free  = !res_valid || !res_stall;

  // Command latch
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      item <= cmd;
    end
  end

  // Sequencer
  always_comb begin
    state_next             = state;
    count_next             = count;
    finish                 = 1'b0;
    ctl.op                 = sbkv_pkg::CELL_HOLD;
    ctl.evict              = evict;
    ctl.key                = item.key;
    ctl.value              = item.value;
    result_next.found      = 1'b0;
    result_next.read_value = '0;
    unique case (state)
      sbkv_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = sbkv_pkg::ST_EXEC;
        end
      end
      sbkv_pkg::ST_EXEC: begin
        unique case (sbkv_pkg::op_t'(item.op))
          sbkv_pkg::OP_INSERT: begin
            if (out_free) begin
              ctl.op     = sbkv_pkg::CELL_INSERT;
              count_next = evict ? count : count + sbkv_pkg::CNT_BITS'(1);
              finish     = 1'b1;
            end
          end
          sbkv_pkg::OP_LOOKUP: begin
            if (out_free) begin
              result_next.found      = stat.found;
              result_next.read_value = stat.read_value;
              finish                 = 1'b1;
            end
          end
          sbkv_pkg::OP_REMOVE: begin
            if (out_free) begin
              ctl.op            = sbkv_pkg::CELL_REMOVE;
              count_next        = count - sbkv_pkg::CNT_BITS'(stat.found);
              result_next.found = stat.found;
              finish            = 1'b1;
            end
          end
          sbkv_pkg::OP_CLEAR: begin
            if (out_free) begin
              count_next = '0;
              finish     = 1'b1;
            end
          end
          sbkv_pkg::OP_TRIM: begin
            // drop the front entry once a cycle until within keep count
            if (count_w > keep_w) begin
              ctl.op     = sbkv_pkg::CELL_SHIFT;
              count_next = count - sbkv_pkg::CNT_BITS'(1);
            end else if (out_free) begin
              finish = 1'b1;
            end
          end
          default: begin
            if (out_free) begin
              finish = 1'b1;
            end
          end
        endcase
        if (finish) begin
          state_next = sbkv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbkv_pkg::ST_IDLE;
      end
    endcase
    result_next.occupancy = sbkv_pkg::OCC_BITS'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbkv_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      res <= result_next;
    end
  end

  sbkv_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count),
    .stat  (stat)
  );

  // Checks
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> state == sbkv_pkg::ST_EXEC)
    else $error("accepted beat did not start execution");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= sbkv_pkg::CNT_BITS'(sbkv_pkg::DEPTH))
    else $error("entry count beyond table depth");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == sbkv_pkg::ST_EXEC)
    else $error("result raised outside execution");

  a_insert_nonempty: assert property (@(posedge clk) disable iff (rst)
    finish && item.op == sbkv_pkg::OP_INSERT |=> count != '0 && res.occupancy != '0)
    else $error("insert left table empty");

endmodule

// ===== tb/sorted_table_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_table_checker: result predictor and checker for the sorted table
// Watches the command, result and register channels of the table. Keeps its
// own copy of the entries and the capacity register, works out each result
// beat when a command beat is taken and compares it with the beats that
// come out, field by field.
// ----------------------------------------------------------------------------
module sorted_table_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  logic                           cmd_stall,
  input  sbkv_pkg::item_t                cmd,
  input  logic                           res_valid,
  input  logic                           res_stall,
  input  sbkv_pkg::result_t              res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [sbkv_pkg::ADDR_BITS-1:0] paddr,
  input  logic [sbkv_pkg::DATA_BITS-1:0] pwdata,
  output int                             errors,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [sbkv_pkg::ADDR_BITS-1:0] CAP_ADDR =
    sbkv_pkg::ADDR_BITS'(4 * sbkv_pkg::REG_CAPACITY);
  localparam int PRINT_LIMIT = 50;

  // Predicted table contents
  logic signed [sbkv_pkg::KEY_BITS-1:0] tbl_key [sbkv_pkg::DEPTH];
  logic [sbkv_pkg::VALUE_BITS-1:0]      tbl_val [sbkv_pkg::DEPTH];
  int unsigned                          tbl_cnt = 0;
  logic [sbkv_pkg::CAP_BITS-1:0]        cap_reg = sbkv_pkg::CAP_RESET;

  sbkv_pkg::result_t due_results [$];
  int                fail_cnt = 0;
  int                due_cnt  = 0;

  assign errors  = fail_cnt;
  assign pending = due_cnt;

  // One line per mismatch; only the first PRINT_LIMIT are printed
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_cnt < PRINT_LIMIT)
      $display("%0t: result %s is %0h, predicted %0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // Remove one entry and close the gap
  function automatic void drop_at(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < tbl_cnt; i++) begin
      tbl_key[i] = tbl_key[i + 1];
      tbl_val[i] = tbl_val[i + 1];
    end
    tbl_cnt--;
  endfunction

  // Apply one command to the predicted table and return its result beat
  function automatic sbkv_pkg::result_t apply_table_op(input sbkv_pkg::item_t it);
    sbkv_pkg::result_t                    r;
    logic signed [sbkv_pkg::KEY_BITS-1:0] k;
    int unsigned                          limit;
    int unsigned                          pos;
    int unsigned                          i;
    r = '0;
    k = it.key;
    case (it.op)
      sbkv_pkg::OP_INSERT: begin
        // capacity 0 acts as 1, anything above DEPTH as DEPTH
        limit = (cap_reg == 0) ? 1 :
                ((cap_reg > sbkv_pkg::DEPTH) ? sbkv_pkg::DEPTH : int'(cap_reg));
        if (tbl_cnt >= limit) drop_at(0);
        // new entry goes after every key less than or equal to it
        pos = 0;
        while (pos < tbl_cnt && tbl_key[pos] <= k) pos++;
        for (i = tbl_cnt; i > pos; i--) begin
          tbl_key[i] = tbl_key[i - 1];
          tbl_val[i] = tbl_val[i - 1];
        end
        tbl_key[pos] = k;
        tbl_val[pos] = it.value;
        tbl_cnt++;
      end
      sbkv_pkg::OP_LOOKUP, sbkv_pkg::OP_REMOVE: begin
        pos = 0;
        while (pos < tbl_cnt && tbl_key[pos] != k) pos++;
        if (pos < tbl_cnt) begin
          r.found = 1'b1;
          if (it.op == sbkv_pkg::OP_LOOKUP) r.read_value = tbl_val[pos];
          else drop_at(pos);
        end
      end
      sbkv_pkg::OP_CLEAR: tbl_cnt = 0;
      sbkv_pkg::OP_TRIM: begin
        while (tbl_cnt > it.keep_count) drop_at(0);
      end
      default: ;
    endcase
    r.occupancy = sbkv_pkg::OCC_BITS'(tbl_cnt);
    return r;
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk) begin : watch
    sbkv_pkg::result_t want;
    if (rst) begin
      tbl_cnt = 0;
      cap_reg = sbkv_pkg::CAP_RESET;
      due_results.delete();
    end else begin
      // result beat against the oldest prediction
      if (res_valid && !res_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("beat with nothing predicted, occupancy", 32'(res.occupancy), 0);
        end else begin
          want = due_results.pop_front();
          if (res.found !== want.found)
            report_mismatch("found", 32'(res.found), 32'(want.found));
          if (res.read_value !== want.read_value)
            report_mismatch("read_value", res.read_value, want.read_value);
          if (res.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(res.occupancy), 32'(want.occupancy));
        end
      end
      if (cmd_valid && !cmd_stall) due_results.push_back(apply_table_op(cmd));
      if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
        cap_reg = pwdata[sbkv_pkg::CAP_BITS-1:0];
    end
    due_cnt = due_results.size();
  end

endmodule

// ===== tb/sorted_bounded_key_value_table_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_bounded_key_value_table_tb: stimulus and verdict for the sorted table
// A directed opening covers empty-table misses, key extremes, equal keys,
// spare op codes, trims and a lowered capacity; then random phases under
// several capacity settings, with random stalls on both sides, a long
// output hold-off and a full drain. The checker module does the comparing.
// ----------------------------------------------------------------------------
module sorted_bounded_key_value_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASE_ITEMS = 75;
  localparam int NUM_PHASES  = 8;
  localparam int TAIL_CYCLES = 40;

  localparam logic [sbkv_pkg::ADDR_BITS-1:0] CAP_ADDR   =
    sbkv_pkg::ADDR_BITS'(4 * sbkv_pkg::REG_CAPACITY);
  localparam logic [sbkv_pkg::ADDR_BITS-1:0] SPARE_ADDR =
    CAP_ADDR + sbkv_pkg::ADDR_BITS'(4);
  localparam logic [sbkv_pkg::OP_BITS-1:0]   OP_SPARE_LO = 3'd5;
  localparam logic [sbkv_pkg::OP_BITS-1:0]   OP_SPARE_HI = 3'd7;
  localparam logic signed [sbkv_pkg::KEY_BITS-1:0] KEY_MIN =
    {1'b1, {(sbkv_pkg::KEY_BITS-1){1'b0}}};
  localparam logic signed [sbkv_pkg::KEY_BITS-1:0] KEY_MAX =
    {1'b0, {(sbkv_pkg::KEY_BITS-1){1'b1}}};
  localparam int unsigned CAP_PLAN [NUM_PHASES] = '{16, 1, 0, 31, 17, 4, 9, 16};

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cmd_valid = 1'b0;
  logic                           cmd_stall;
  sbkv_pkg::item_t                cmd       = '0;
  logic                           res_valid;
  logic                           res_stall = 1'b0;
  sbkv_pkg::result_t              res;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [sbkv_pkg::ADDR_BITS-1:0] paddr     = '0;
  logic [sbkv_pkg::DATA_BITS-1:0] pwdata    = '0;
  logic [sbkv_pkg::DATA_BITS-1:0] prdata;
  logic                           pready;

  int mismatch_count;
  int pending_count;
  int idle_cycles = 0;

  bit long_hold  = 1'b0;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b1;

  logic signed [sbkv_pkg::KEY_BITS-1:0] key_pool [8];

  sorted_bounded_key_value_table dut (
    .clk, .rst,
    .cmd_valid, .cmd_stall, .cmd,
    .res_valid, .res_stall, .res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sorted_table_checker checker_i (
    .clk, .rst,
    .cmd_valid, .cmd_stall, .cmd,
    .res_valid, .res_stall, .res,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors (mismatch_count),
    .pending(pending_count)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: cycles with no beat taken on any channel
  always @(posedge clk) begin
    if (rst || psel || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stall bursts, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (long_hold) begin
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        res_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  function automatic sbkv_pkg::item_t mk_item(
      input logic [sbkv_pkg::OP_BITS-1:0]          op,
      input logic signed [sbkv_pkg::KEY_BITS-1:0]  key,
      input logic [sbkv_pkg::VALUE_BITS-1:0]       value,
      input logic [sbkv_pkg::KEEP_BITS-1:0]        keep);
    sbkv_pkg::item_t it;
    it.op         = op;
    it.key        = key;
    it.value      = value;
    it.keep_count = keep;
    return it;
  endfunction

  // Random command: keys mostly from a small pool so lookups and removes hit
  function automatic sbkv_pkg::item_t random_item();
    sbkv_pkg::item_t it;
    int unsigned     r;
    it.value      = $urandom;
    it.keep_count = sbkv_pkg::KEEP_BITS'($urandom_range(0, 31));
    r = $urandom_range(0, 9);
    if (r < 5)      it.key = key_pool[$urandom_range(0, 7)];
    else if (r < 7) it.key = sbkv_pkg::KEY_BITS'(int'($urandom_range(0, 8)) - 4);
    else            it.key = $urandom;
    r = $urandom_range(0, 99);
    if (r < 40)      it.op = sbkv_pkg::OP_INSERT;
    else if (r < 60) it.op = sbkv_pkg::OP_LOOKUP;
    else if (r < 78) it.op = sbkv_pkg::OP_REMOVE;
    else if (r < 88) it.op = sbkv_pkg::OP_TRIM;
    else if (r < 92) it.op = sbkv_pkg::OP_CLEAR;
    else             it.op = sbkv_pkg::OP_BITS'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return it;
  endfunction

  // Offer one command beat, starting at a falling edge; returns at the
  // falling edge after it is taken
  task automatic send(input sbkv_pkg::item_t it);
    cmd       <= it;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
  endtask

  task automatic tx_gap(input int unsigned n);
    cmd_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Stop offering and wait for every predicted result to arrive
  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic [sbkv_pkg::ADDR_BITS-1:0] addr,
                           input logic [sbkv_pkg::DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Main sequence
  initial begin
    int unsigned cap;
    int          i;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty table misses and trim
    send(mk_item(sbkv_pkg::OP_LOOKUP, '0, '0, '0));
    send(mk_item(sbkv_pkg::OP_REMOVE, '0, '0, '0));
    send(mk_item(sbkv_pkg::OP_TRIM,   '0, '0, '0));
    // key extremes, value extremes, equal keys keep insertion order
    send(mk_item(sbkv_pkg::OP_INSERT, KEY_MIN, '0, '0));
    send(mk_item(sbkv_pkg::OP_INSERT, KEY_MAX, '1, '0));
    send(mk_item(sbkv_pkg::OP_INSERT, '0, 32'h1111_1111, '0));
    send(mk_item(sbkv_pkg::OP_INSERT, '1, 32'haaaa_aaaa, '0));
    send(mk_item(sbkv_pkg::OP_INSERT, '0, 32'h2222_2222, '0));
    send(mk_item(sbkv_pkg::OP_LOOKUP, '0, '0, '0));
    send(mk_item(sbkv_pkg::OP_REMOVE, '0, '0, '0));
    send(mk_item(sbkv_pkg::OP_LOOKUP, '0, '0, '0));
    send(mk_item(sbkv_pkg::OP_LOOKUP, KEY_MIN, '0, '0));
    send(mk_item(sbkv_pkg::OP_LOOKUP, 32'sd5, '0, '0));
    // spare op codes change nothing
    for (i = OP_SPARE_LO; i <= OP_SPARE_HI; i++)
      send(mk_item(sbkv_pkg::OP_BITS'(i), KEY_MAX, '1, '1));
    // trim at or above occupancy, then a real trim, then clear
    send(mk_item(sbkv_pkg::OP_TRIM,   '0, '0, '1));
    send(mk_item(sbkv_pkg::OP_TRIM,   '0, '0, sbkv_pkg::KEEP_BITS'(2)));
    send(mk_item(sbkv_pkg::OP_CLEAR,  '0, '0, '0));
    send(mk_item(sbkv_pkg::OP_LOOKUP, KEY_MAX, '0, '0));
    // capacity lowered below occupancy: insert evicts only one entry
    for (i = 0; i < 5; i++) send(mk_item(sbkv_pkg::OP_INSERT, $urandom, $urandom, '0));
    drain();
    write_reg(CAP_ADDR, sbkv_pkg::DATA_BITS'(2));
    send(mk_item(sbkv_pkg::OP_INSERT, $urandom, $urandom, '0));
    send(mk_item(sbkv_pkg::OP_TRIM,   '0, '0, '0));

    // Random phases, one capacity setting each
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      cap = (ph == 6) ? $urandom_range(0, 31) : CAP_PLAN[ph];
      write_reg(CAP_ADDR, sbkv_pkg::DATA_BITS'(cap));
      if (ph == 3) write_reg(SPARE_ADDR, $urandom);
      key_pool[$urandom_range(4, 7)] = $urandom;
      tx_idle_on = (ph != 1) && (ph != NUM_PHASES - 1);
      rx_idle_on = (ph != NUM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // output held off while commands keep coming
        if (ph == 1 && n == 0) long_hold = 1'b1;
        // sender waits for the table to go empty of work
        if (ph == 4 && n == PHASE_ITEMS / 2) drain();
        send(random_item());
        if (tx_idle_on && $urandom_range(0, 4) == 0) tx_gap($urandom_range(1, 9));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/sbkv_pkg.sv
rtl/core/sbkv_cell.sv
rtl/core/sbkv_chain.sv
rtl/core/sorted_bounded_key_value_table.sv
tb/sorted_table_checker.sv
tb/sorted_bounded_key_value_table_tb.sv
